>>> hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Width and reset value of the capacity register
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/spq_in_if.sv
`default_nettype none

interface spq_in_if #(
    parameter int KEY_BITS = 16
);
    logic                       valid;
    logic                       ready;
    spq_pkg::op_t               opcode;
    logic signed [KEY_BITS-1:0] key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spq_out_if.sv
`default_nettype none

interface spq_out_if #(
    parameter int KEY_BITS = 16,
    parameter int CNT_BITS = 5
);
    logic                       valid;
    logic                       ready;
    spq_pkg::status_t           status;
    logic signed [KEY_BITS-1:0] served_key;
    logic [CNT_BITS-1:0]        occupancy;

    modport source (output valid, output status, output served_key, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input served_key, input occupancy,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spq_cell.sv
`default_nettype none

module spq_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                       clk,
    input  spq_pkg::cell_cmd_t         cmd,
    input  logic signed [KEY_BITS-1:0] new_key,
    input  logic signed [KEY_BITS-1:0] left_key,
    input  logic                       left_gt,
    input  logic signed [KEY_BITS-1:0] right_key,
    input  logic                       occupied,
    output logic signed [KEY_BITS-1:0] key,
    output logic                       gt
);
    import spq_pkg::*;

    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;

    // Stored key stays ahead of the new one only when strictly greater
    assign gt  = occupied && (new_key < key_reg);
    assign key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (cmd.insert_en)
        begin
            if (gt)
                key_next = key_reg;
            else if (left_gt)
                key_next = new_key;
            else
                key_next = left_key;
        end
        else if (cmd.remove_en)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of key cells, largest key at the head.
//
// Channels: req carries opcode (insert or remove) and a signed key; rsp returns
// one transaction per request with status, served_key and occupancy.
// cfg_wr_en/cfg_wr_data write the capacity limit; values above DEPTH act as
// DEPTH. Write it only while no transaction is in flight.
//
// Throughput: one request per cycle unless the output register stalls. Every
// cell compares the incoming key with its own and picks keep, load or shift in
// the same cycle, so an insert or a remove finishes in one pass over the chain.
// Response: it appears in the cycle after the request is accepted, held
// in an output register.
//
// Reset: count goes to zero and the capacity limit to 16. Cell contents are
// not cleared; only cells below the count are ever read.
//
// Stall: while rsp is not taken, the output register holds and req.ready drops
// only if that register is full and not being drained.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [spq_pkg::CAP_BITS-1:0]     cfg_wr_data,
    spq_in_if.sink                           req,
    spq_out_if.source                        rsp
);
    import spq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    logic [CAP_BITS-1:0]        cap_reg;
    logic [CNT_BITS-1:0]        count_reg;
    logic [CNT_BITS-1:0]        count_next;
    logic                       rsp_valid_reg;
    status_t                    status_reg;
    status_t                    status_next;
    logic signed [KEY_BITS-1:0] served_reg;
    logic signed [KEY_BITS-1:0] served_next;
    logic [CNT_BITS-1:0]        occ_reg;

    logic [CMP_BITS-1:0]        eff_limit;
    logic                       accept;
    logic                       is_insert;
    logic                       full;
    logic                       empty;
    cell_cmd_t                  cmd;

    logic signed [KEY_BITS-1:0] cell_key [DEPTH];
    logic                       cell_gt  [DEPTH];
    logic                       cell_occ [DEPTH];

    assign eff_limit = (CMP_BITS'(cap_reg) > CMP_BITS'(DEPTH))
                       ? CMP_BITS'(DEPTH)
                       : CMP_BITS'(cap_reg);

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_insert = (req.opcode == OP_INSERT);
    assign full      = CMP_BITS'(count_reg) >= eff_limit;
    assign empty     = (count_reg == '0);

    assign cmd.insert_en = accept && is_insert && !full;
    assign cmd.remove_en = accept && !is_insert && !empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign cell_occ[g] = (CMP_BITS'(g) < CMP_BITS'(count_reg));

            if (g == 0)
            begin : g_head
                spq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .new_key   (req.key),
                    .left_key  (req.key),
                    .left_gt   (1'b1),
                    .right_key (cell_key[(DEPTH > 1) ? 1 : 0]),
                    .occupied  (cell_occ[g]),
                    .key       (cell_key[g]),
                    .gt        (cell_gt[g])
                );
            end
            else if (g == DEPTH - 1)
            begin : g_tail
                spq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .new_key   (req.key),
                    .left_key  (cell_key[g-1]),
                    .left_gt   (cell_gt[g-1]),
                    .right_key (cell_key[g]),
                    .occupied  (cell_occ[g]),
                    .key       (cell_key[g]),
                    .gt        (cell_gt[g])
                );
            end
            else
            begin : g_mid
                spq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .new_key   (req.key),
                    .left_key  (cell_key[g-1]),
                    .left_gt   (cell_gt[g-1]),
                    .right_key (cell_key[g+1]),
                    .occupied  (cell_occ[g]),
                    .key       (cell_key[g]),
                    .gt        (cell_gt[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        served_next = '0;
        if (is_insert)
        begin
            if (full)
                status_next = ST_FULL;
            else
                count_next = count_reg + CNT_BITS'(1);
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                served_next = cell_key[0];
                count_next  = count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload of the response register, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            served_reg <= served_next;
            occ_reg    <= count_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.served_key = served_reg;
    assign rsp.occupancy  = occ_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        CMP_BITS'(count_reg) <= CMP_BITS'(DEPTH))
        else $error("count exceeds depth");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert_en |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("insert did not grow count");

    a_reject_holds : assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cmd.insert_en && !cmd.remove_en |=> $stable(count_reg))
        else $error("rejected transaction changed count");

    a_serve_head : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove_en |=> served_reg == $past(cell_key[0]))
        else $error("served key is not the former head");

    a_occ_matches : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> occ_reg == count_reg)
        else $error("reported occupancy differs from count");

endmodule

`default_nettype wire

>>> tb/sv/sorted_priority_queue_test.sv
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int KEY_BITS       = 16;
    localparam int CNT_BITS       = 5;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 43;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        status_t                    status;
        logic signed [KEY_BITS-1:0] served_key;
        logic [CNT_BITS-1:0]        occupancy;
    } queue_reply_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CAPACITY
    } row_kind_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    typedef struct {
        row_kind_t                  kind;
        op_t                        op;
        logic signed [KEY_BITS-1:0] key;
        bit                         typed;
        status_t                    status;
        logic signed [KEY_BITS-1:0] served;
        logic [CNT_BITS-1:0]        occupancy;
        logic [CAP_BITS-1:0]        cap_value;
    } stim_row_t;

    // Rows with typed = 1 carry their own expected reply; the rest use the shadow queue.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b1, ST_EMPTY, 16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sd32767,  1'b1, ST_DONE,  16'sd0,      5'd1, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sh8000,   1'b1, ST_DONE,  16'sd0,      5'd2, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, -16'sd1,     1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sd1,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sh5555,   1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'shAAAA,   1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sh1234,   1'b1, ST_DONE,  16'sd32767,  5'd7, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'shFFFF,   1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b1, ST_DONE,  16'sh8000,   5'd0, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sh7FFF,   1'b1, ST_EMPTY, 16'sd0,      5'd0, 5'd0},
        '{ROW_CAPACITY, OP_INSERT, 16'sd0,  1'b0, ST_DONE,  16'sd0,      5'd0, 5'd2},
        '{ROW_ITEM, OP_INSERT, 16'sd100,    1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, -16'sd100,   1'b0, ST_DONE,  16'sd0,      5'd0, 5'd0},
        '{ROW_ITEM, OP_INSERT, 16'sd5,      1'b1, ST_FULL,  16'sd0,      5'd2, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b1, ST_DONE,  16'sd100,    5'd1, 5'd0},
        '{ROW_ITEM, OP_REMOVE, 16'sd0,      1'b1, ST_DONE,  -16'sd100,   5'd0, 5'd0}
    };

    // Capacity per random phase; a fill-heavy phase precedes most small capacities
    // so the limit regularly drops below the occupancy.
    localparam logic [CAP_BITS-1:0] PHASE_CAPACITY [PHASES] =
        '{5'd31, 5'd2, 5'd0, 5'd16, 5'd1, 5'd5, 5'd17, 5'd4, 5'd16, 5'd3};
    localparam int PHASE_INSERT_PCT [PHASES] = '{85, 40, 50, 75, 30, 60, 80, 50, 55, 30};

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CAP_BITS-1:0] cfg_wr_data;

    spq_in_if  #(.KEY_BITS(KEY_BITS))                       req_if ();
    spq_out_if #(.KEY_BITS(KEY_BITS), .CNT_BITS(CNT_BITS))  rsp_if ();

    sorted_priority_queue #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    // Shadow copy of the queue contents and the capacity register
    logic signed [KEY_BITS-1:0] shadow_keys [DEPTH];
    int                         shadow_count;
    logic [CAP_BITS-1:0]        shadow_capacity;

    queue_reply_t awaited_replies [$];
    queue_reply_t expected_reply;
    int           error_count;
    int           burst_left;
    int           idle_cycles;
    ready_mode_t  ready_mode;
    int           ready_window;
    logic [7:0]   ready_pattern;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic queue_reply_t apply_request(op_t op, logic signed [KEY_BITS-1:0] new_key);
        queue_reply_t reply;
        int           limit;
        int           pos;
        reply = '0;
        reply.status = ST_DONE;
        limit = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
        if (op == OP_INSERT) begin
            if (shadow_count >= limit) begin
                reply.status = ST_FULL;
            end
            else begin
                // New key goes ahead of older equal keys
                pos = 0;
                while (pos < shadow_count && new_key < shadow_keys[pos])
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_keys[i] = shadow_keys[i-1];
                shadow_keys[pos] = new_key;
                shadow_count++;
            end
        end
        else begin
            if (shadow_count == 0) begin
                reply.status = ST_EMPTY;
            end
            else begin
                reply.served_key = shadow_keys[0];
                for (int i = 0; i + 1 < shadow_count; i++)
                    shadow_keys[i] = shadow_keys[i+1];
                shadow_count--;
            end
        end
        reply.occupancy = shadow_count[CNT_BITS-1:0];
        return reply;
    endfunction

    task automatic send_item(input op_t op, input logic signed [KEY_BITS-1:0] new_key,
                             input bit typed, input queue_reply_t typed_reply);
        int           gap;
        queue_reply_t predicted;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.key    <= new_key;
        do @(posedge clk); while (!req_if.ready);
        predicted = apply_request(op, new_key);
        awaited_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // Hold the request channel idle until every reply is back, then let the pipe settle
    task automatic drain_replies();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        shadow_capacity = value;
        cfg_wr_en   <= 1'b0;
    endtask

    // Response side: check each transaction and pick the next ready value
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_replies.size() == 0) begin
                error_count++;
                $display("%0t: reply with none expected, actual status %0d key %0d occ %0d",
                         $time, rsp_if.status, rsp_if.served_key, rsp_if.occupancy);
            end
            else begin
                expected_reply = awaited_replies.pop_front();
                if (rsp_if.status !== expected_reply.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, expected_reply.status, rsp_if.status);
                end
                if (rsp_if.served_key !== expected_reply.served_key) begin
                    error_count++;
                    $display("%0t: served_key expected %0d actual %0d",
                             $time, expected_reply.served_key, rsp_if.served_key);
                end
                if (rsp_if.occupancy !== expected_reply.occupancy) begin
                    error_count++;
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, expected_reply.occupancy, rsp_if.occupancy);
                end
            end
        end
        if (ready_window == 0) begin
            ready_window  = $urandom_range(20, 100);
            ready_mode    = ready_mode_t'($urandom_range(0, 2));
            ready_pattern = 8'($urandom) | 8'h01;
        end
        ready_window--;
        ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
        case (ready_mode)
            READY_ALWAYS: rsp_if.ready <= 1'b1;
            READY_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
            default:      rsp_if.ready <= ready_pattern[0];
        endcase
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        op_t                        op;
        logic signed [KEY_BITS-1:0] rand_key;
        int                         insert_pct;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_if.valid   = 1'b0;
        req_if.opcode  = OP_INSERT;
        req_if.key     = '0;
        rsp_if.ready   = 1'b0;
        error_count    = 0;
        burst_left     = 0;
        ready_window   = 0;
        shadow_count   = 0;
        shadow_capacity = CAP_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CAPACITY) begin
                drain_replies();
                write_capacity(directed_rows[r].cap_value);
            end
            else begin
                send_item(directed_rows[r].op, directed_rows[r].key, directed_rows[r].typed,
                          '{directed_rows[r].status, directed_rows[r].served,
                            directed_rows[r].occupancy});
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_replies();
            write_capacity(PHASE_CAPACITY[p]);
            insert_pct = PHASE_INSERT_PCT[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Swing the mix now and then to sweep the fill level
                if ($urandom_range(0, 15) == 0)
                    insert_pct = $urandom_range(15, 90);
                op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
                case ($urandom_range(0, 9))
                    0:       rand_key = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
                    1:       rand_key = KEY_BITS'($urandom_range(0, 2)) - 16'sd1;
                    2, 3:    rand_key = KEY_BITS'($urandom_range(0, 8)) - 16'sd4;
                    default: rand_key = KEY_BITS'($urandom);
                endcase
                send_item(op, rand_key, 1'b0, '0);
                if ($urandom_range(0, 59) == 0)
                    drain_replies();
            end
        end

        drain_replies();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_in_if.sv
hw/rtl/spq_out_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_test.sv
